FILE: design/assert_macros.svh
// Assertion macros for the cosine similarity RTL (used by csim_ctrl).
// Included by bare file name; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define CSIM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define CSIM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: design/csim_pkg.sv
// Package for the cosine similarity stream unit: payload types, command struct, constants.
// Used by csim_ctrl, csim_datapath and cosine_similarity_stream_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csim_pkg;

    // Element width is fixed by the request and result formats (Q1.15).
    localparam int ELEM_WIDTH = 16;
    // Default width of the three saturating accumulators.
    localparam int ACC_WIDTH_DEF = 48;

    // One request: a pair of matching elements and the end-of-vector mark.
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] elem_a;
        logic signed [ELEM_WIDTH-1:0] elem_b;
        logic                         last_elem;
    } t_req;

    // One result: similarity in Q1.15 and the zero denominator flag.
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] similarity;
        logic                         zero_denominator;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // register the products of the request on the ports
        logic load;       // prime the multiplier, root and divider registers
        logic mul_step;   // one shift-add step of norm_a * norm_b
        logic sqrt_step;  // one digit of the integer square root
        logic div_step;   // one quotient bit of the division
        logic emit;       // drive the result and clear the sums
    } t_cmd;

endpackage

`default_nettype wire

FILE: design/csim_ctrl.sv
// Controller for the cosine similarity stream unit: phase sequencer and step counter.
// Depends on csim_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module csim_ctrl #(
    parameter int ACC_WIDTH = csim_pkg::ACC_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic           i_last,
    output logic                o_busy,
    output csim_pkg::t_cmd      o_cmd
);

    // Longest phase is the division, one step per numerator bit.
    localparam int NUM_WIDTH = ACC_WIDTH + csim_pkg::ELEM_WIDTH - 1;
    localparam int CNT_W     = $clog2(NUM_WIDTH);
    localparam logic [CNT_W-1:0] LAST_ACC = CNT_W'(ACC_WIDTH - 1);
    localparam logic [CNT_W-1:0] LAST_NUM = CNT_W'(NUM_WIDTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WAIT = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // Requests stream in while idle; any other phase holds them off.
    assign o_busy = (r_state != S_IDLE);

    // Next state, counter and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = start;
                if (start && i_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // The products of the last request are added to the sums here.
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == LAST_ACC) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == LAST_ACC) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == LAST_NUM) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `CSIM_ASSERT(a_busy_after_last, i_clk, i_rst_n, $rose(o_busy) |-> $past(o_cmd.take && i_last), "busy rose without an accepted last request")
    `CSIM_ASSERT(a_emit_then_idle, i_clk, i_rst_n, o_cmd.emit |=> (r_state == S_IDLE), "controller did not return to idle after a result")
    `CSIM_ASSERT(a_one_command, i_clk, i_rst_n, $onehot0({o_cmd.take, o_cmd.load, o_cmd.mul_step, o_cmd.sqrt_step, o_cmd.div_step, o_cmd.emit}), "more than one datapath command at once")
    `CSIM_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > LAST_NUM, "step counter out of range")

endmodule

`default_nettype wire

FILE: design/csim_datapath.sv
// Datapath of the cosine similarity stream unit: products, saturating sums,
// shift-add multiplier, digit-by-digit square root and restoring divider. Depends on csim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csim_datapath #(
    parameter int ACC_WIDTH = csim_pkg::ACC_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire csim_pkg::t_cmd i_cmd,
    input  wire csim_pkg::t_req i_req,
    output csim_pkg::t_res      o_res,
    output logic                o_res_valid
);

    localparam int EW        = csim_pkg::ELEM_WIDTH;
    localparam int PW        = 2 * EW;
    localparam int SW        = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
    localparam int MW        = 2 * ACC_WIDTH;
    localparam int RW        = ACC_WIDTH + 2;
    localparam int NUM_WIDTH = ACC_WIDTH + EW - 1;

    // Add a product to a sum and clamp at the signed accumulator limits.
    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] s,
        input logic signed [PW-1:0]        p
    );
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        sum = SW'(s) + SW'(p);
        mx  = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
        mn  = ~mx;
        if (sum > mx) begin
            sat_add = mx[ACC_WIDTH-1:0];
        end else if (sum < mn) begin
            sat_add = mn[ACC_WIDTH-1:0];
        end else begin
            sat_add = sum[ACC_WIDTH-1:0];
        end
    endfunction

    logic signed [PW-1:0]        r_prod_ab;
    logic signed [PW-1:0]        r_prod_aa;
    logic signed [PW-1:0]        r_prod_bb;
    logic                        r_prod_vld;
    logic signed [ACC_WIDTH-1:0] r_dot;
    logic signed [ACC_WIDTH-1:0] r_norm_a;
    logic signed [ACC_WIDTH-1:0] r_norm_b;
    logic [ACC_WIDTH-1:0]        r_mb;
    logic [MW-1:0]               r_mprod;
    logic [RW-1:0]               r_sq_rem;
    logic [ACC_WIDTH-1:0]        r_root;
    logic [NUM_WIDTH-1:0]        r_num;
    logic [ACC_WIDTH-1:0]        r_dv_rem;
    logic [EW-1:0]               r_q;
    logic                        r_big;
    csim_pkg::t_res              r_res;
    logic                        r_res_valid;

    logic [ACC_WIDTH-1:0] w_mag;
    logic [RW+1:0]        w_rem_sh;
    logic [RW+1:0]        w_trial;
    logic                 w_sq_ge;
    logic [ACC_WIDTH:0]   w_rem2;
    logic [ACC_WIDTH:0]   w_den;
    logic                 w_dv_ge;
    logic [EW-1:0]        w_lim;
    logic [EW-1:0]        w_qsat;
    csim_pkg::t_res       w_res;

    // Stage one: full-precision products of the accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.take;
        end
        if (i_cmd.take) begin
            r_prod_ab <= i_req.elem_a * i_req.elem_b;
            r_prod_aa <= i_req.elem_a * i_req.elem_a;
            r_prod_bb <= i_req.elem_b * i_req.elem_b;
        end
    end

    // Stage two: saturating sums, cleared when a result leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_dot    <= '0;
            r_norm_a <= '0;
            r_norm_b <= '0;
        end else if (r_prod_vld) begin
            r_dot    <= sat_add(r_dot, r_prod_ab);
            r_norm_a <= sat_add(r_norm_a, r_prod_aa);
            r_norm_b <= sat_add(r_norm_b, r_prod_bb);
        end
    end

    // Magnitude of the dot product; the most negative sum maps to 2^(ACC_WIDTH-1).
    assign w_mag = r_dot[ACC_WIDTH-1] ? $unsigned(-r_dot) : $unsigned(r_dot);

    // Square root step: bring down two product bits and try the next root bit.
    assign w_rem_sh = {r_sq_rem, r_mprod[MW-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_sq_ge  = (w_rem_sh >= w_trial);

    // Division step: bring down one numerator bit and try the divisor.
    assign w_rem2   = {r_dv_rem, r_num[NUM_WIDTH-1]};
    assign w_den    = {1'b0, r_root};
    assign w_dv_ge  = (w_rem2 >= w_den);

    // Iterative multiplier, square root and divider, chained through r_mprod and r_root.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mb     <= $unsigned(r_norm_b);
            r_mprod  <= '0;
            r_sq_rem <= '0;
            r_root   <= '0;
            r_num    <= {w_mag, {(EW-1){1'b0}}};
            r_dv_rem <= '0;
            r_q      <= '0;
            r_big    <= 1'b0;
        end else if (i_cmd.mul_step) begin
            r_mprod <= {r_mprod[MW-2:0], 1'b0}
                     + (r_mb[ACC_WIDTH-1] ? {{ACC_WIDTH{1'b0}}, r_norm_a} : {MW{1'b0}});
            r_mb    <= {r_mb[ACC_WIDTH-2:0], 1'b0};
        end else if (i_cmd.sqrt_step) begin
            r_mprod <= {r_mprod[MW-3:0], 2'b00};
            if (w_sq_ge) begin
                r_sq_rem <= RW'(w_rem_sh - w_trial);
                r_root   <= {r_root[ACC_WIDTH-2:0], 1'b1};
            end else begin
                r_sq_rem <= RW'(w_rem_sh);
                r_root   <= {r_root[ACC_WIDTH-2:0], 1'b0};
            end
        end else if (i_cmd.div_step) begin
            r_num    <= {r_num[NUM_WIDTH-2:0], 1'b0};
            r_dv_rem <= w_dv_ge ? ACC_WIDTH'(w_rem2 - w_den) : ACC_WIDTH'(w_rem2);
            r_q      <= {r_q[EW-2:0], w_dv_ge};
            // A quotient bit shifted past the result width means it cannot fit.
            r_big    <= r_big | r_q[EW-1];
        end
    end

    // Sign, saturation and zero denominator handling of the quotient.
    assign w_lim = {1'b1, {(EW-1){1'b0}}};
    always_comb begin
        w_qsat = r_q;
        w_res  = '0;
        if (r_root == '0) begin
            w_res.zero_denominator = 1'b1;
        end else if (r_dot[ACC_WIDTH-1]) begin
            if (r_big || (r_q > w_lim)) begin
                w_qsat = w_lim;
            end
            w_res.similarity = $signed(-w_qsat);
        end else begin
            if (r_big || r_q[EW-1]) begin
                w_qsat = {1'b0, {(EW-1){1'b1}}};
            end
            w_res.similarity = $signed(w_qsat);
        end
    end

    // Result register with its one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_res <= w_res;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

`default_nettype wire

FILE: design/cosine_similarity_stream_unit.sv
// Top level of the cosine similarity stream unit.
// Depends on csim_pkg, csim_ctrl and csim_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Element pairs are taken one per clock while busy is low: a request is accepted
// at each rising edge with start high and busy low. The pair marked last_elem
// closes the vector; busy then stays high through the wait and load steps,
// the bit-serial product of the two norms (one step per accumulator bit), the
// digit-by-digit square root (one digit per accumulator bit), the restoring
// divider (one quotient bit per numerator bit) and the done step. The result
// appears on o_res for exactly one cycle, marked by o_res_valid, in the first
// cycle that busy is low again; the receiver cannot stall it and must take it
// then. The accumulators are cleared as the result leaves, so the next vector
// may start in that same cycle.

module cosine_similarity_stream_unit #(
    parameter int ACC_WIDTH = csim_pkg::ACC_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire csim_pkg::t_req i_req,
    output csim_pkg::t_res      o_res,
    output logic                o_res_valid
);

    csim_pkg::t_cmd w_cmd;

    // Phase sequencing.
    csim_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_req.last_elem),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Arithmetic and result register.
    csim_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for cosine_similarity_stream_unit: streams element pairs, predicts each
// vector's Q1.15 similarity and compares it with every strobed result.
// Depends on csim_pkg and the cosine_similarity_stream_unit RTL.
`timescale 1ns / 1ps

module tb;

    localparam int ELEM_W = csim_pkg::ELEM_WIDTH;
    localparam int ACC_W = csim_pkg::ACC_WIDTH_DEF;
    localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam logic [127:0] SIM_LIM = 128'd1 << (ELEM_W - 1);
    localparam int EL_MAX = (1 <<< (ELEM_W - 1)) - 1;
    localparam int EL_MIN = -(1 <<< (ELEM_W - 1));
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int RAND_PER_PHASE = 500;

    // Vector shapes used by the random part.
    typedef enum int {
        VEC_RANDOM, VEC_SAME, VEC_OPPOSITE, VEC_ZERO_A, VEC_ZERO_B,
        VEC_TINY, VEC_CORNERS, VEC_SCALED
    } t_vec_kind;

    // A request waiting to be driven, with the sender behavior for it.
    typedef struct {
        csim_pkg::t_req req;
        int unsigned    idle_pct;
        bit             drain_first;
    } t_pending;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    csim_pkg::t_req i_req = '0;
    logic           busy;
    csim_pkg::t_res o_res;
    logic           o_res_valid;

    t_pending       pending_reqs[$];
    csim_pkg::t_res sims_due[$];
    longint   dot_acc = 0;
    longint   norm_a_acc = 0;
    longint   norm_b_acc = 0;
    logic     req_fired = 1'b0;
    int       quiet_cycles = 0;
    int       error_count = 0;
    int       reqs_taken = 0;
    int       results_seen = 0;
    int       zero_den_count = 0;
    int       clamped_count = 0;

    cosine_similarity_stream_unit #(
        .ACC_WIDTH(ACC_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res      (o_res),
        .o_res_valid(o_res_valid)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Adds one product to a sum, clamping at the signed accumulator limits.
    function automatic longint clamp_add(input longint sum, input longint prod);
        if (prod > 0 && sum > ACC_MAX - prod) begin
            return ACC_MAX;
        end
        if (prod < 0 && sum < ACC_MIN - prod) begin
            return ACC_MIN;
        end
        return sum + prod;
    endfunction

    // Similarity of a finished vector: dot scaled by 2^15 over floor(sqrt(norm_a*norm_b)).
    function automatic csim_pkg::t_res cosine_from_sums(input longint dot, input longint na,
                                                        input longint nb);
        logic [127:0]   nprod;
        logic [127:0]   trial;
        logic [127:0]   quo;
        logic [63:0]    root;
        logic [63:0]    mag;
        csim_pkg::t_res sim;
        nprod = {64'd0, na} * {64'd0, nb};
        root = '0;
        for (int k = 62; k >= 0; k--) begin
            trial = {64'd0, root | (64'd1 << k)};
            if (trial * trial <= nprod) begin
                root = root | (64'd1 << k);
            end
        end
        sim = '0;
        if (root == 0) begin
            sim.zero_denominator = 1'b1;
        end else begin
            mag = (dot < 0) ? -dot : dot;
            quo = ({64'd0, mag} << (ELEM_W - 1)) / {64'd0, root};
            if (dot < 0) begin
                if (quo > SIM_LIM) begin
                    quo = SIM_LIM;
                end
                quo = 128'd0 - quo;
            end else if (quo >= SIM_LIM) begin
                quo = SIM_LIM - 1;
            end
            sim.similarity = quo[ELEM_W-1:0];
        end
        return sim;
    endfunction

    // Folds one accepted request into the sums and queues a result on the last pair.
    task automatic absorb_pair(input csim_pkg::t_req r);
        longint         a;
        longint         b;
        csim_pkg::t_res sim;
        a = longint'(signed'(r.elem_a));
        b = longint'(signed'(r.elem_b));
        dot_acc = clamp_add(dot_acc, a * b);
        norm_a_acc = clamp_add(norm_a_acc, a * a);
        norm_b_acc = clamp_add(norm_b_acc, b * b);
        if (r.last_elem) begin
            sim = cosine_from_sums(dot_acc, norm_a_acc, norm_b_acc);
            sims_due.insert(sims_due.size(), sim);
            if (sim.zero_denominator) begin
                zero_den_count++;
            end else if (int'(sim.similarity) == EL_MAX || int'(sim.similarity) == EL_MIN) begin
                clamped_count++;
            end
            dot_acc = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
        end
    endtask

    task automatic queue_pair(input int a, input int b, input int last,
                              input int unsigned idle_pct, input int drain_first);
        t_pending p;
        p.req.elem_a = ELEM_W'(a);
        p.req.elem_b = ELEM_W'(b);
        p.req.last_elem = (last != 0);
        p.idle_pct = idle_pct;
        p.drain_first = (drain_first != 0);
        pending_reqs.insert(pending_reqs.size(), p);
    endtask

    function automatic int corner_value();
        case ($urandom_range(5))
            0: return EL_MIN;
            1: return EL_MIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return EL_MAX;
        endcase
    endfunction

    // Queues one vector of the given shape and length.
    task automatic queue_vector(input t_vec_kind kind, input int len,
                                input int unsigned idle_pct, input bit drain_first);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            a = ELEM_W'($urandom);
            b = ELEM_W'($urandom);
            case (kind)
                VEC_SAME:     b = a;
                VEC_OPPOSITE: b = -a;
                VEC_ZERO_A:   a = '0;
                VEC_ZERO_B:   b = '0;
                VEC_TINY: begin
                    a = ELEM_W'($signed($urandom_range(127)) - 64);
                    b = ELEM_W'($signed($urandom_range(127)) - 64);
                end
                VEC_CORNERS: begin
                    a = ELEM_W'(corner_value());
                    b = ELEM_W'(corner_value());
                end
                VEC_SCALED: begin
                    b = ELEM_W'((a >>> $urandom_range(3)) + $signed($urandom_range(7)) - 3);
                end
                default: ;
            endcase
            queue_pair(int'(a), int'(b), int'(i == len - 1), idle_pct,
                       int'(drain_first && i == 0));
        end
    endtask

    task automatic queue_random_phase(input int unsigned idle_pct);
        int        count;
        int        len;
        t_vec_kind kind;
        count = 0;
        while (count < RAND_PER_PHASE) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
            case ($urandom_range(11))
                0, 1, 2, 3: kind = VEC_RANDOM;
                4:          kind = VEC_SAME;
                5:          kind = VEC_OPPOSITE;
                6:          kind = VEC_ZERO_A;
                7:          kind = VEC_ZERO_B;
                8:          kind = VEC_TINY;
                9:          kind = VEC_CORNERS;
                default:    kind = VEC_SCALED;
            endcase
            queue_vector(kind, len, idle_pct, count == 0);
            count += len;
        end
    endtask

    // Driver: a new request goes out at the falling edge once the previous one was taken.
    always @(negedge i_clk) begin
        logic           next_start;
        csim_pkg::t_req next_req;
        bit             gap;
        t_pending       head;
        next_start = start;
        next_req = i_req;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else if (!start || req_fired) begin
            next_start = 1'b0;
            if (pending_reqs.size() != 0) begin
                gap = ($urandom_range(99) < pending_reqs[0].idle_pct);
                if (pending_reqs[0].drain_first && sims_due.size() != 0) begin
                    gap = 1'b1;
                end
                if (!gap) begin
                    head = pending_reqs.pop_front();
                    next_req = head.req;
                    next_start = 1'b1;
                end
            end
        end
        start <= next_start;
        i_req <= next_req;
    end

    // Monitor: checks a strobed result first, then predicts from an accepted request.
    always @(posedge i_clk) begin
        csim_pkg::t_res want;
        req_fired <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_res_valid === 1'b1) begin
                results_seen++;
                if (sims_due.size() == 0) begin
                    $display("%0t: unexpected result, similarity %0d zero_denominator %0b",
                             $time, o_res.similarity, o_res.zero_denominator);
                    error_count++;
                end else begin
                    want = sims_due.pop_front();
                    if (o_res.similarity !== want.similarity) begin
                        $display("%0t: similarity mismatch, expected %0d, actual %0d",
                                 $time, want.similarity, o_res.similarity);
                        error_count++;
                    end
                    if (o_res.zero_denominator !== want.zero_denominator) begin
                        $display("%0t: zero_denominator mismatch, expected %0b, actual %0b",
                                 $time, want.zero_denominator, o_res.zero_denominator);
                        error_count++;
                    end
                end
            end
            if (start && busy === 1'b0) begin
                reqs_taken++;
                absorb_pair(i_req);
            end
        end
    end

    // Watchdog on cycles in which no request and no result moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && busy === 1'b0) || o_res_valid === 1'b1) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        // Directed vectors: single pairs, full-scale corners, zero norms, orthogonal.
        queue_pair(1, 1, 1, 0, 0);
        queue_pair(EL_MAX, EL_MIN, 1, 0, 0);
        queue_pair(EL_MIN, EL_MIN, 1, 0, 0);
        queue_pair(EL_MAX, EL_MAX, 1, 0, 0);
        queue_pair(EL_MIN, EL_MAX, 1, 0, 0);
        queue_pair(0, 0, 1, 0, 0);
        queue_pair(0, 5, 1, 0, 0);
        queue_pair(-7, 0, 1, 0, 0);
        queue_pair(-1, -1, 1, 0, 0);
        queue_pair(1, 0, 0, 0, 0);
        queue_pair(0, 1, 1, 0, 0);
        queue_pair(EL_MIN, EL_MIN, 0, 0, 0);
        queue_pair(EL_MAX, EL_MAX, 1, 0, 0);
        queue_pair(100, 200, 0, 0, 0);
        queue_pair(-300, 50, 0, 0, 0);
        queue_pair(7, -7, 1, 0, 0);
        queue_pair(EL_MAX, -1, 0, 0, 0);
        queue_pair(EL_MIN, 1, 0, 0, 0);
        queue_pair('h5555, 'h2AAA, 1, 0, 0);
        queue_pair(0, 0, 0, 0, 0);
        queue_pair(0, EL_MIN, 1, 0, 0);

        // Random vectors with a steady sender, a mostly idle one, and a lightly idle one.
        queue_random_phase(0);
        queue_random_phase(77);
        queue_random_phase(25);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || sims_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d results over directed and random vectors.",
                 reqs_taken, results_seen);
        $display("Zero-denominator results: %0d, full-scale similarities: %0d.",
                 zero_den_count, clamped_count);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
